FILE: design/lsb_pkg.sv
// Shared types and constants of the link supervisor with backoff.
package lsb_pkg;

  localparam int COUNT_WIDTH_DEF = 32;
  localparam int NUM_CNT         = 5;

  // Counter slots
  localparam int CNT_CONNECTS    = 0;
  localparam int CNT_DISCONNECTS = 1;
  localparam int CNT_PING_FAIL   = 2;
  localparam int CNT_CREATE_FAIL = 3;
  localparam int CNT_SPIN_FAIL   = 4;

  // Action codes, both reported and requested
  localparam logic [2:0] ACT_WAIT    = 3'd0;
  localparam logic [2:0] ACT_PING    = 3'd1;
  localparam logic [2:0] ACT_CREATE  = 3'd2;
  localparam logic [2:0] ACT_SPIN    = 3'd3;
  localparam logic [2:0] ACT_DESTROY = 3'd4;

  // Register indexes
  localparam logic [2:0] REG_BACKOFF_MIN = 3'd0;
  localparam logic [2:0] REG_BACKOFF_MAX = 3'd1;
  localparam logic [2:0] REG_ALIVE_PING  = 3'd2;
  localparam logic [2:0] REG_PING_RETRY  = 3'd3;
  localparam logic [2:0] REG_FAIL_LIMIT  = 3'd4;

  // Register reset values
  localparam logic [15:0] RST_BACKOFF_MIN = 16'd500;
  localparam logic [15:0] RST_BACKOFF_MAX = 16'd8000;
  localparam logic [15:0] RST_ALIVE_PING  = 16'd1000;
  localparam logic [15:0] RST_PING_RETRY  = 16'd100;
  localparam logic [7:0]  RST_FAIL_LIMIT  = 8'd3;

  typedef struct packed {
    logic [15:0] backoff_min_ms;
    logic [15:0] backoff_max_ms;
    logic [15:0] alive_ping_ms;
    logic [15:0] ping_retry_ms;
    logic [7:0]  ping_fail_limit;
  } cfg_t;

  typedef struct packed {
    logic [31:0] spin_failures;
    logic [31:0] create_failures;
    logic [31:0] ping_failures;
    logic [31:0] disconnects;
    logic [31:0] connects;
    logic [31:0] state_entered_ms;
    logic        stop_request;
    logic        motors_allowed;
    logic [1:0]  link_state;
    logic [2:0]  next_action;
  } res_t;

endpackage

FILE: design/link_supervisor_with_backoff_unit.sv
// Link supervisor with exponential backoff: one result word for every input
// word, one word per cycle sustained while the sink keeps up; in_tready
// drops when the output buffer is full. The link state update, the wrap-safe
// deadline check and the choice of the next action all happen in the cycle a
// word is taken; the result then sits in a two-entry output buffer, so a new
// word is accepted while an earlier result still waits for the sink.
// Configuration writes are taken at any time (cfg_ready is always high) and
// belong between words only.
module link_supervisor_with_backoff_unit #(
  parameter int COUNT_WIDTH = lsb_pkg::COUNT_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  // now_ms[31:0], opcode[34:32], ok[35], take_stop[36], zero pad[39:37]
  input  logic [39:0]  in_tdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // next_action[2:0], link_state[4:3], motors_allowed[5], stop_request[6],
  // state_entered_ms[38:7], connects[70:39], disconnects[102:71],
  // ping_failures[134:103], create_failures[166:135],
  // spin_failures[198:167], zero pad[199]
  output logic [199:0] out_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  lsb_pkg::cfg_t cfg_r;
  lsb_pkg::res_t res;
  lsb_pkg::res_t head_r, skid_r;
  logic [1:0]    count_r;
  logic          push, pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.backoff_min_ms  <= lsb_pkg::RST_BACKOFF_MIN;
      cfg_r.backoff_max_ms  <= lsb_pkg::RST_BACKOFF_MAX;
      cfg_r.alive_ping_ms   <= lsb_pkg::RST_ALIVE_PING;
      cfg_r.ping_retry_ms   <= lsb_pkg::RST_PING_RETRY;
      cfg_r.ping_fail_limit <= lsb_pkg::RST_FAIL_LIMIT;
    end else if (cfg_valid) begin
      case (cfg_index)
        lsb_pkg::REG_BACKOFF_MIN: cfg_r.backoff_min_ms  <= cfg_data;
        lsb_pkg::REG_BACKOFF_MAX: cfg_r.backoff_max_ms  <= cfg_data;
        lsb_pkg::REG_ALIVE_PING:  cfg_r.alive_ping_ms   <= cfg_data;
        lsb_pkg::REG_PING_RETRY:  cfg_r.ping_retry_ms   <= cfg_data;
        lsb_pkg::REG_FAIL_LIMIT:  cfg_r.ping_fail_limit <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  assign in_tready  = (count_r != 2'd2);
  assign out_tvalid = (count_r != 2'd0);
  assign push       = in_tvalid & in_tready;
  assign pop        = out_tvalid & out_tready;

  lsb_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (push),
    .now_ms    (in_tdata[31:0]),
    .opcode    (in_tdata[34:32]),
    .ok        (in_tdata[35]),
    .take_stop (in_tdata[36]),
    .cfg       (cfg_r),
    .res       (res)
  );

  // Two-entry output buffer: head drives the port, skid catches a word
  // that arrives while the head is stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10: count_r <= count_r + 2'd1;
        2'b01: count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b10: begin
        if (count_r == 2'd0) begin
          head_r <= res;
        end else begin
          skid_r <= res;
        end
      end
      2'b01: begin
        head_r <= skid_r;
      end
      2'b11: begin
        if (count_r == 2'd1) begin
          head_r <= res;
        end else begin
          head_r <= skid_r;
          skid_r <= res;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_tdata = {1'b0, head_r};

`ifndef ASSERT_OFF
  a_ready_low_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && count_r == 2'd2))
    else $error("input stalled while output buffer not full");

  a_push_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> out_tvalid)
    else $error("accepted word produced no pending result");

  a_stall_holds_head: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(head_r)))
    else $error("stalled result word changed");

  a_motors_match_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (head_r.motors_allowed == (head_r.link_state == 2'd2)))
    else $error("motor enable disagrees with link state");
`endif

endmodule

FILE: design/lsb_core.sv
// Link state machine: applies one report per word and picks the next action.
module lsb_core #(
  parameter int COUNT_WIDTH = lsb_pkg::COUNT_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          acc,
  input  logic [31:0]   now_ms,
  input  logic [2:0]    opcode,
  input  logic          ok,
  input  logic          take_stop,
  input  lsb_pkg::cfg_t cfg,
  output lsb_pkg::res_t res
);

  typedef enum logic [1:0] {
    ST_WAITING      = 2'd0,
    ST_AVAILABLE    = 2'd1,
    ST_CONNECTED    = 2'd2,
    ST_DISCONNECTED = 2'd3
  } link_st_t;

  link_st_t                st_r, st_nxt;
  logic [31:0]             entered_r, entered_nxt;
  logic [31:0]             deadline_r, deadline_nxt;
  logic [7:0]              streak_r, streak_nxt;
  logic [15:0]             backoff_r, backoff_nxt;
  logic                    stop_r, stop_nxt;
  logic [COUNT_WIDTH-1:0]  cnt_r [lsb_pkg::NUM_CNT];
  logic [lsb_pkg::NUM_CNT-1:0] bump;

  logic        go;
  link_st_t    target;
  logic        dl_set;
  logic [15:0] dl_delta;
  logic [16:0] twice;
  logic [7:0]  streak_inc;
  logic [31:0] diff;
  logic        due;
  logic        stop_after;
  logic [2:0]  action;

  assign twice      = {backoff_r, 1'b0};
  assign streak_inc = (streak_r == 8'hFF) ? streak_r : streak_r + 8'd1;

  always_comb begin
    go          = 1'b0;
    target      = st_r;
    dl_set      = 1'b0;
    dl_delta    = '0;
    bump        = '0;
    streak_nxt  = streak_r;
    backoff_nxt = backoff_r;
    case (opcode)
      lsb_pkg::ACT_PING: begin
        if (st_r == ST_WAITING) begin
          if (ok) begin
            backoff_nxt = cfg.backoff_min_ms;
            streak_nxt  = '0;
            go          = 1'b1;
            target      = ST_AVAILABLE;
          end else begin
            bump[lsb_pkg::CNT_PING_FAIL] = 1'b1;
            dl_set      = 1'b1;
            dl_delta    = backoff_r;
            backoff_nxt = (twice > {1'b0, cfg.backoff_max_ms}) ? cfg.backoff_max_ms
                                                               : twice[15:0];
          end
        end else if (st_r == ST_CONNECTED) begin
          if (ok) begin
            streak_nxt = '0;
            dl_set     = 1'b1;
            dl_delta   = cfg.alive_ping_ms;
          end else begin
            bump[lsb_pkg::CNT_PING_FAIL] = 1'b1;
            streak_nxt = streak_inc;
            if (streak_inc >= cfg.ping_fail_limit) begin
              bump[lsb_pkg::CNT_DISCONNECTS] = 1'b1;
              go     = 1'b1;
              target = ST_DISCONNECTED;
            end else begin
              dl_set   = 1'b1;
              dl_delta = cfg.ping_retry_ms;
            end
          end
        end
      end
      lsb_pkg::ACT_CREATE: begin
        if (st_r == ST_AVAILABLE) begin
          go = 1'b1;
          if (ok) begin
            bump[lsb_pkg::CNT_CONNECTS] = 1'b1;
            streak_nxt = '0;
            dl_set     = 1'b1;
            dl_delta   = cfg.alive_ping_ms;
            target     = ST_CONNECTED;
          end else begin
            bump[lsb_pkg::CNT_CREATE_FAIL] = 1'b1;
            bump[lsb_pkg::CNT_DISCONNECTS] = 1'b1;
            target = ST_DISCONNECTED;
          end
        end
      end
      lsb_pkg::ACT_SPIN: begin
        if (st_r == ST_CONNECTED && !ok) begin
          bump[lsb_pkg::CNT_SPIN_FAIL]   = 1'b1;
          bump[lsb_pkg::CNT_DISCONNECTS] = 1'b1;
          go     = 1'b1;
          target = ST_DISCONNECTED;
        end
      end
      lsb_pkg::ACT_DESTROY: begin
        if (st_r == ST_DISCONNECTED) begin
          streak_nxt  = '0;
          backoff_nxt = cfg.backoff_min_ms;
          dl_set      = 1'b1;
          dl_delta    = cfg.backoff_min_ms;
          go          = 1'b1;
          target      = ST_WAITING;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    st_nxt       = go ? target : st_r;
    entered_nxt  = go ? now_ms : entered_r;
    deadline_nxt = dl_set ? now_ms + 32'(dl_delta) : deadline_r;
    stop_after   = stop_r | (go && st_r == ST_CONNECTED && target != ST_CONNECTED);
    stop_nxt     = take_stop ? 1'b0 : stop_after;
    // A fresh deadline is now + delta, so it is already due only for a zero delta
    diff = now_ms - deadline_r;
    due  = dl_set ? (dl_delta == 16'd0) : !diff[31];
    case (st_nxt)
      ST_WAITING:   action = due ? lsb_pkg::ACT_PING : lsb_pkg::ACT_WAIT;
      ST_AVAILABLE: action = lsb_pkg::ACT_CREATE;
      ST_CONNECTED: action = due ? lsb_pkg::ACT_PING : lsb_pkg::ACT_SPIN;
      default:      action = lsb_pkg::ACT_DESTROY;
    endcase
  end

  always_comb begin
    res.next_action      = action;
    res.link_state       = st_nxt;
    res.motors_allowed   = (st_nxt == ST_CONNECTED);
    res.stop_request     = take_stop & stop_after;
    res.state_entered_ms = entered_nxt;
    res.connects         = 32'(cnt_r[lsb_pkg::CNT_CONNECTS] +
                               COUNT_WIDTH'(bump[lsb_pkg::CNT_CONNECTS]));
    res.disconnects      = 32'(cnt_r[lsb_pkg::CNT_DISCONNECTS] +
                               COUNT_WIDTH'(bump[lsb_pkg::CNT_DISCONNECTS]));
    res.ping_failures    = 32'(cnt_r[lsb_pkg::CNT_PING_FAIL] +
                               COUNT_WIDTH'(bump[lsb_pkg::CNT_PING_FAIL]));
    res.create_failures  = 32'(cnt_r[lsb_pkg::CNT_CREATE_FAIL] +
                               COUNT_WIDTH'(bump[lsb_pkg::CNT_CREATE_FAIL]));
    res.spin_failures    = 32'(cnt_r[lsb_pkg::CNT_SPIN_FAIL] +
                               COUNT_WIDTH'(bump[lsb_pkg::CNT_SPIN_FAIL]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_WAITING;
      entered_r  <= '0;
      deadline_r <= '0;
      streak_r   <= '0;
      backoff_r  <= lsb_pkg::RST_BACKOFF_MIN;
      stop_r     <= 1'b0;
      for (int i = 0; i < lsb_pkg::NUM_CNT; i++) begin
        cnt_r[i] <= '0;
      end
    end else if (acc) begin
      st_r       <= st_nxt;
      entered_r  <= entered_nxt;
      deadline_r <= deadline_nxt;
      streak_r   <= streak_nxt;
      backoff_r  <= backoff_nxt;
      stop_r     <= stop_nxt;
      for (int i = 0; i < lsb_pkg::NUM_CNT; i++) begin
        if (bump[i]) begin
          cnt_r[i] <= cnt_r[i] + COUNT_WIDTH'(1);
        end
      end
    end
  end

endmodule

FILE: verif/link_supervisor_with_backoff_checker.sv
// Checker for the link supervisor: predicts every result word and compares it with the block.
module link_supervisor_with_backoff_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic [39:0]  in_tdata,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [199:0] out_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  output int           fail_count,
  output int           pending,
  output int           compared
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {
    LINK_WAITING   = 2'd0,
    LINK_AVAILABLE = 2'd1,
    LINK_CONNECTED = 2'd2,
    LINK_DOWN      = 2'd3
  } link_t;

  lsb_pkg::cfg_t settings;
  link_t         lk_state;
  logic [31:0]   lk_entered;
  logic [31:0]   lk_deadline;
  logic [7:0]    lk_streak;
  logic [15:0]   lk_backoff;
  logic          lk_stop;
  logic [31:0]   tally [lsb_pkg::NUM_CNT];

  lsb_pkg::res_t awaited_results [$];
  lsb_pkg::res_t got;
  lsb_pkg::res_t want;

  function automatic logic deadline_due(logic [31:0] now, logic [31:0] due_at);
    logic [31:0] gap;
    gap = now - due_at;
    return !gap[31];
  endfunction

  function automatic void move_to(logic [31:0] now, link_t target);
    if (lk_state == LINK_CONNECTED && target != LINK_CONNECTED) begin
      lk_stop = 1'b1;
    end
    lk_state   = target;
    lk_entered = now;
  endfunction

  function automatic void bump(int slot);
    tally[slot] = tally[slot] + 32'd1;
  endfunction

  function automatic void apply_ping(logic [31:0] now, logic ok);
    logic [16:0] twice;
    if (lk_state == LINK_WAITING) begin
      if (ok) begin
        lk_backoff = settings.backoff_min_ms;
        lk_streak  = 8'd0;
        move_to(now, LINK_AVAILABLE);
      end else begin
        bump(lsb_pkg::CNT_PING_FAIL);
        lk_deadline = now + 32'(lk_backoff);
        twice       = {lk_backoff, 1'b0};
        lk_backoff  = (twice > {1'b0, settings.backoff_max_ms}) ?
                      settings.backoff_max_ms : twice[15:0];
      end
    end else if (lk_state == LINK_CONNECTED) begin
      if (ok) begin
        lk_streak   = 8'd0;
        lk_deadline = now + 32'(settings.alive_ping_ms);
      end else begin
        bump(lsb_pkg::CNT_PING_FAIL);
        if (lk_streak != 8'hFF) begin
          lk_streak = lk_streak + 8'd1;
        end
        if (lk_streak >= settings.ping_fail_limit) begin
          bump(lsb_pkg::CNT_DISCONNECTS);
          move_to(now, LINK_DOWN);
        end else begin
          lk_deadline = now + 32'(settings.ping_retry_ms);
        end
      end
    end
  endfunction

  // Apply the reported outcome, choose the next action, then read the stop edge
  function automatic lsb_pkg::res_t next_link_result(logic [39:0] word);
    logic [31:0]   now;
    logic [2:0]    op;
    logic          ok;
    logic          take;
    logic          due;
    lsb_pkg::res_t res;
    now  = word[31:0];
    op   = word[34:32];
    ok   = word[35];
    take = word[36];
    res  = '0;

    case (op)
      lsb_pkg::ACT_PING: apply_ping(now, ok);
      lsb_pkg::ACT_CREATE: begin
        if (lk_state == LINK_AVAILABLE) begin
          if (ok) begin
            bump(lsb_pkg::CNT_CONNECTS);
            lk_streak   = 8'd0;
            lk_deadline = now + 32'(settings.alive_ping_ms);
            move_to(now, LINK_CONNECTED);
          end else begin
            bump(lsb_pkg::CNT_CREATE_FAIL);
            bump(lsb_pkg::CNT_DISCONNECTS);
            move_to(now, LINK_DOWN);
          end
        end
      end
      lsb_pkg::ACT_SPIN: begin
        if (lk_state == LINK_CONNECTED && !ok) begin
          bump(lsb_pkg::CNT_SPIN_FAIL);
          bump(lsb_pkg::CNT_DISCONNECTS);
          move_to(now, LINK_DOWN);
        end
      end
      lsb_pkg::ACT_DESTROY: begin
        if (lk_state == LINK_DOWN) begin
          lk_streak   = 8'd0;
          lk_backoff  = settings.backoff_min_ms;
          lk_deadline = now + 32'(settings.backoff_min_ms);
          move_to(now, LINK_WAITING);
        end
      end
      default: ;
    endcase

    due = deadline_due(now, lk_deadline);
    case (lk_state)
      LINK_WAITING:   res.next_action = due ? lsb_pkg::ACT_PING : lsb_pkg::ACT_WAIT;
      LINK_AVAILABLE: res.next_action = lsb_pkg::ACT_CREATE;
      LINK_CONNECTED: res.next_action = due ? lsb_pkg::ACT_PING : lsb_pkg::ACT_SPIN;
      default:        res.next_action = lsb_pkg::ACT_DESTROY;
    endcase

    if (take) begin
      res.stop_request = lk_stop;
      lk_stop          = 1'b0;
    end
    res.link_state       = lk_state;
    res.motors_allowed   = (lk_state == LINK_CONNECTED);
    res.state_entered_ms = lk_entered;
    res.connects         = tally[lsb_pkg::CNT_CONNECTS];
    res.disconnects      = tally[lsb_pkg::CNT_DISCONNECTS];
    res.ping_failures    = tally[lsb_pkg::CNT_PING_FAIL];
    res.create_failures  = tally[lsb_pkg::CNT_CREATE_FAIL];
    res.spin_failures    = tally[lsb_pkg::CNT_SPIN_FAIL];
    return res;
  endfunction

  task automatic compare_field(string label, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      fail_count = fail_count + 1;
      $display("%0t ns: %s expected %0h, got %0h", $time, label, exp_val, act_val);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      settings.backoff_min_ms  = lsb_pkg::RST_BACKOFF_MIN;
      settings.backoff_max_ms  = lsb_pkg::RST_BACKOFF_MAX;
      settings.alive_ping_ms   = lsb_pkg::RST_ALIVE_PING;
      settings.ping_retry_ms   = lsb_pkg::RST_PING_RETRY;
      settings.ping_fail_limit = lsb_pkg::RST_FAIL_LIMIT;
      lk_state    = LINK_WAITING;
      lk_entered  = '0;
      lk_deadline = '0;
      lk_streak   = '0;
      lk_backoff  = lsb_pkg::RST_BACKOFF_MIN;
      lk_stop     = 1'b0;
      for (int i = 0; i < lsb_pkg::NUM_CNT; i++) begin
        tally[i] = '0;
      end
      awaited_results.delete();
      fail_count = 0;
      pending    = 0;
      compared   = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lsb_pkg::REG_BACKOFF_MIN: settings.backoff_min_ms  = cfg_data;
          lsb_pkg::REG_BACKOFF_MAX: settings.backoff_max_ms  = cfg_data;
          lsb_pkg::REG_ALIVE_PING:  settings.alive_ping_ms   = cfg_data;
          lsb_pkg::REG_PING_RETRY:  settings.ping_retry_ms   = cfg_data;
          lsb_pkg::REG_FAIL_LIMIT:  settings.ping_fail_limit = cfg_data[7:0];
          default: ;
        endcase
      end

      // Compare before queuing: a word taken now cannot come out at this edge
      if (out_tvalid && out_tready) begin
        got = out_tdata[198:0];
        if (awaited_results.size() == 0) begin
          fail_count = fail_count + 1;
          $display("%0t ns: result word %0h arrived with nothing expected", $time, got);
        end else begin
          want = awaited_results.pop_front();
          compare_field("next_action", want.next_action, got.next_action);
          compare_field("link_state", want.link_state, got.link_state);
          compare_field("motors_allowed", want.motors_allowed, got.motors_allowed);
          compare_field("stop_request", want.stop_request, got.stop_request);
          compare_field("state_entered_ms", want.state_entered_ms, got.state_entered_ms);
          compare_field("connects", want.connects, got.connects);
          compare_field("disconnects", want.disconnects, got.disconnects);
          compare_field("ping_failures", want.ping_failures, got.ping_failures);
          compare_field("create_failures", want.create_failures, got.create_failures);
          compare_field("spin_failures", want.spin_failures, got.spin_failures);
          compared = compared + 1;
        end
      end

      if (in_tvalid && in_tready) begin
        awaited_results.push_back(next_link_result(in_tdata));
      end
      pending = awaited_results.size();
    end
  end

endmodule

FILE: verif/link_supervisor_with_backoff_unit_test.sv
// Top of the link supervisor testbench: clock, reset, stimulus and verdict.
module link_supervisor_with_backoff_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int PHASES          = 8;
  localparam int WORDS_PER_PHASE = 105;
  localparam int HOLD_CYCLES     = 300;
  localparam int IDLE_PCT        = 8;

  // Opcodes the block treats as no report at all
  localparam logic [2:0] OP_SPARE_LO  = 3'd5;
  localparam logic [2:0] OP_SPARE_MID = 3'd6;
  localparam logic [2:0] OP_SPARE_HI  = 3'd7;
  // First register index past the last real register
  localparam logic [2:0] REG_UNUSED_FIRST = 3'd5;

  logic         clk = 1'b0;
  logic         rst_n;
  // now_ms[31:0], opcode[34:32], ok[35], take_stop[36], zero pad[39:37]
  logic [39:0]  in_tdata;
  logic         in_tvalid;
  logic         in_tready;
  // next_action[2:0], link_state[4:3], motors_allowed[5], stop_request[6],
  // state_entered_ms[38:7], connects[70:39], disconnects[102:71],
  // ping_failures[134:103], create_failures[166:135],
  // spin_failures[198:167], zero pad[199]
  logic [199:0] out_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [2:0]   cfg_index;
  logic [15:0]  cfg_data;

  int           fail_count;
  int           pending;
  int           compared;
  int           cycle_count = 0;
  logic         calm;
  int           hold_ask;
  int           hold_served;
  logic [2:0]   seen_action;
  logic [31:0]  clock_ms;
  int           step_max;
  int           report_count;
  int           setting_count;

  link_supervisor_with_backoff_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  link_supervisor_with_backoff_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending),
    .compared   (compared)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding", cycle_count, pending);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Follow the block's last requested action so most reports make sense
  always @(posedge clk) begin
    if (!rst_n) begin
      seen_action <= lsb_pkg::ACT_WAIT;
    end else if (out_tvalid && out_tready) begin
      seen_action <= out_tdata[2:0];
    end
  end

  // Sink side: random stalls, plus a long hold-off whenever one is asked for
  initial begin
    int hold_left;
    out_tready  = 1'b0;
    hold_served = 0;
    forever begin
      @(negedge clk);
      if (hold_ask != hold_served) begin
        out_tready <= 1'b0;
        hold_left = HOLD_CYCLES;
        while (hold_left > 0) begin
          @(negedge clk);
          hold_left = hold_left - 1;
        end
        hold_served = hold_served + 1;
      end else begin
        out_tready <= (rst_n && (calm || $urandom_range(99) >= IDLE_PCT));
      end
    end
  end

  task automatic send_report(logic [31:0] now, logic [2:0] op, logic ok, logic take);
    @(negedge clk);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tdata  <= {3'b000, take, ok, op, now};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  // Drop valid and wait until every result is back, with idle slack after it
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_all(int bmin, int bmax, int alive, int retry, int limit);
    write_reg(lsb_pkg::REG_BACKOFF_MIN, 16'(bmin));
    write_reg(lsb_pkg::REG_BACKOFF_MAX, 16'(bmax));
    write_reg(lsb_pkg::REG_ALIVE_PING, 16'(alive));
    write_reg(lsb_pkg::REG_PING_RETRY, 16'(retry));
    write_reg(lsb_pkg::REG_FAIL_LIMIT, {8'($urandom_range(0, 255)), 8'(limit)});
    setting_count = setting_count + 1;
  endtask

  // Mostly report what the block asked for, some random reports, some noise
  task automatic random_report();
    logic [2:0] op;
    logic       ok;
    logic       take;
    int         pick;
    int         rate;
    int         jump;
    pick = $urandom_range(99);
    jump = $urandom_range(99);
    if (jump < 1) begin
      clock_ms = $urandom;
    end else if (jump < 5) begin
      clock_ms = clock_ms + $urandom_range(0, 200000);
    end else begin
      clock_ms = clock_ms + $urandom_range(0, step_max);
    end

    if (pick < 75) begin
      op = seen_action;
      case (op)
        lsb_pkg::ACT_PING:   rate = 60;
        lsb_pkg::ACT_CREATE: rate = 80;
        lsb_pkg::ACT_SPIN:   rate = 88;
        default:             rate = 50;
      endcase
      ok = ($urandom_range(99) < rate);
      report_count = report_count + 1;
    end else if (pick < 90) begin
      op = 3'($urandom_range(lsb_pkg::ACT_PING, lsb_pkg::ACT_DESTROY));
      ok = 1'($urandom_range(1));
      report_count = report_count + 1;
    end else begin
      case ($urandom_range(3))
        0:       op = lsb_pkg::ACT_WAIT;
        1:       op = OP_SPARE_LO;
        2:       op = OP_SPARE_MID;
        default: op = OP_SPARE_HI;
      endcase
      ok = 1'($urandom_range(1));
    end
    take = ($urandom_range(99) < 30);
    send_report(clock_ms, op, ok, take);
  endtask

  initial begin
    int  phase_end;
    logic held;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    cfg_valid     = 1'b0;
    cfg_index     = lsb_pkg::REG_BACKOFF_MIN;
    cfg_data      = '0;
    calm          = 1'b0;
    hold_ask      = 0;
    step_max      = 400;
    report_count  = 0;
    setting_count = 1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: backoff, keepalive loss, wrap-safe deadlines, failed create and spin
    send_report(32'd0, lsb_pkg::ACT_WAIT, 1'b0, 1'b0);
    send_report(32'd5, lsb_pkg::ACT_PING, 1'b0, 1'b0);
    send_report(32'd504, lsb_pkg::ACT_WAIT, 1'b1, 1'b0);
    send_report(32'd505, lsb_pkg::ACT_WAIT, 1'b0, 1'b0);
    send_report(32'd600, lsb_pkg::ACT_PING, 1'b0, 1'b1);
    send_report(32'd700, lsb_pkg::ACT_PING, 1'b1, 1'b0);
    send_report(32'd710, lsb_pkg::ACT_SPIN, 1'b1, 1'b0);
    send_report(32'd720, lsb_pkg::ACT_CREATE, 1'b1, 1'b0);
    send_report(32'd1720, lsb_pkg::ACT_SPIN, 1'b1, 1'b0);
    send_report(32'd1721, lsb_pkg::ACT_PING, 1'b0, 1'b0);
    send_report(32'd1821, lsb_pkg::ACT_PING, 1'b0, 1'b0);
    send_report(32'd1921, lsb_pkg::ACT_PING, 1'b0, 1'b1);
    send_report(32'd1930, lsb_pkg::ACT_PING, 1'b1, 1'b1);
    send_report(32'd2000, lsb_pkg::ACT_DESTROY, 1'b0, 1'b0);
    send_report(32'd2500 + 32'h7FFF_FFFF, lsb_pkg::ACT_WAIT, 1'b0, 1'b0);
    send_report(32'd2500 + 32'h8000_0000, OP_SPARE_HI, 1'b1, 1'b0);
    send_report(32'd2500, lsb_pkg::ACT_PING, 1'b1, 1'b0);
    send_report(32'd2510, lsb_pkg::ACT_CREATE, 1'b0, 1'b0);
    send_report(32'hFFFF_FF00, lsb_pkg::ACT_DESTROY, 1'b1, 1'b1);
    send_report(32'hFFFF_FFFF, OP_SPARE_LO, 1'b0, 1'b0);
    send_report(32'h0000_00F4, lsb_pkg::ACT_PING, 1'b1, 1'b0);
    send_report(32'h0000_0100, lsb_pkg::ACT_CREATE, 1'b1, 1'b0);
    send_report(32'h0000_0200, OP_SPARE_MID, 1'b1, 1'b0);
    send_report(32'h0000_0300, lsb_pkg::ACT_SPIN, 1'b0, 1'b0);
    send_report(32'h0000_0400, lsb_pkg::ACT_DESTROY, 1'b0, 1'b1);
    clock_ms = 32'h0000_0400;
    settle();

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        1: begin
          write_all(1, 1, 1, 1, 1);
          step_max = 3;
        end
        2: begin
          write_all(65535, 65535, 65535, 65535, 255);
          step_max = 40000;
        end
        3: begin
          // minimum above maximum: clamped on the first doubling
          write_all(5000, 300, 700, 50, 2);
          step_max = 800;
        end
        4: begin
          write_all(1, 65535, 200, 10, 4);
          step_max = 300;
        end
        5: begin
          write_all($urandom_range(1, 2000), $urandom_range(1, 20000),
                    $urandom_range(1, 3000), $urandom_range(1, 500), $urandom_range(1, 6));
          write_reg(REG_UNUSED_FIRST + 3'($urandom_range(0, 2)), 16'($urandom));
          step_max = $urandom_range(10, 2000);
        end
        6, 7: begin
          write_all($urandom_range(1, 65535), $urandom_range(1, 65535),
                    $urandom_range(1, 65535), $urandom_range(1, 65535),
                    $urandom_range(1, 255));
          step_max = $urandom_range(10, 30000);
        end
        default: ;
      endcase
      calm      = (phase == 3);
      held      = 1'b0;
      phase_end = report_count + WORDS_PER_PHASE;
      while (report_count < phase_end) begin
        // Hold the sink off while reports keep coming, so the block backs up
        if ((phase == 2 || phase == 6) && !held && report_count + 90 >= phase_end) begin
          hold_ask = hold_ask + 1;
          held     = 1'b1;
        end
        random_report();
      end
      settle();
    end

    repeat (8) @(posedge clk);
    $display("Drove %0d report words plus noise under %0d register settings; %0d compared.",
             report_count + 25, setting_count, compared);
    $display("Covered backoff doubling and clamping, keepalive loss, failed create and spin, ",
             "stop-edge reads, deadline wrap and sink hold-off.");
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/lsb_pkg.sv
design/lsb_core.sv
design/link_supervisor_with_backoff_unit.sv
verif/link_supervisor_with_backoff_checker.sv
verif/link_supervisor_with_backoff_unit_test.sv
